// ===== design/zvd_pkg.sv =====
// Shared widths, register indexes and control/status types for the
// zero-velocity detector. No dependencies.
package zvd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = 28;
    localparam int BSUM_W     = 56;
    localparam int MAG_W      = 24;
    localparam int CNT_W      = 16;
    localparam int BIAS_W     = 32;
    localparam int MAX_SUB    = 16;
    localparam int IDX_W      = 5;
    localparam int NN_W       = 5;
    localparam int WIN_W      = 16;
    localparam int SMW_W      = 11;
    localparam int THR_W      = 24;
    localparam int RATE_W     = 13;
    localparam int PROD_W     = SMW_W + MAG_W;
    localparam int DIV_W      = 70;
    localparam int DEN_W      = 28;
    localparam int STEP_W     = 7;
    localparam int RAD_W      = 58;
    localparam int ROOT_W     = 29;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 168;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BWIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd5;

    // operand selection of the shared divider
    typedef enum logic [1:0] {
        DIV_AVG  = 2'd0,
        DIV_BIAS = 2'd1,
        DIV_MEAN = 2'd2,
        DIV_DEV  = 2'd3
    } div_op_t;

    typedef struct packed {
        logic    accept;
        logic    div_start;
        div_op_t div_op;
        logic    sq_mul;
        logic    sq_add;
        logic    axis_clr;
        logic    axis_inc;
        logic    sqrt_start;
        logic    mag_load;
        logic    bias_gather;
        logic    bias_clear;
        logic    mul_start;
        logic    bias_store;
        logic    bias_done_set;
        logic    mean_seed;
        logic    mean_mul;
        logic    mean_load;
        logic    dev_seed;
        logic    dev_mul;
        logic    dev_load;
        logic    stat_update;
        logic    out_load;
    } zvd_cmd_t;

    typedef struct packed {
        logic ep_end;
        logic div_busy;
        logic sqrt_busy;
        logic mul_busy;
        logic axis_last;
        logic aligned;
        logic gather;
        logic bias_now;
        logic seen;
        logic dev_zero;
        logic out_free;
    } zvd_sts_t;

endpackage

// ===== design/zvd_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on zvd_pkg. Dividend comes left aligned to the requested step count.
module zvd_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [zvd_pkg::DIV_W-1:0]   dividend,
    input  logic [zvd_pkg::DEN_W-1:0]   divisor,
    input  logic [zvd_pkg::STEP_W-1:0]  steps,
    output logic                        busy,
    output logic [zvd_pkg::DIV_W-1:0]   quotient
);
    import zvd_pkg::*;

    logic [DIV_W-1:0]  quo_reg,  quo_next;
    logic [DEN_W-1:0]  rem_reg,  rem_next;
    logic [DEN_W-1:0]  den_reg,  den_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    // shift one dividend bit into the remainder, subtract when it fits
    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, den_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = steps;
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// ===== design/zvd_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on zvd_pkg.
module zvd_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [zvd_pkg::RAD_W-1:0]   radicand,
    output logic                        busy,
    output logic [zvd_pkg::ROOT_W-1:0]  root
);
    import zvd_pkg::*;

    localparam int REM_W = ROOT_W + 3;

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [4:0]        cnt_reg,  cnt_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'(ROOT_W);
        end else if (cnt_reg != '0) begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

endmodule

// ===== design/zvd_datapath.sv =====
// Datapath: configuration registers, epoch and bias sums, running means,
// still counter, bias multiply, output register. Uses zvd_div, zvd_sqrt, zvd_pkg.
module zvd_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  zvd_pkg::zvd_cmd_t               cmd,
    output zvd_pkg::zvd_sts_t               sts,
    input  logic [zvd_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tlast,
    input  logic                            s_tuser,
    input  logic                            cfg_valid,
    input  logic [zvd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [zvd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [zvd_pkg::M_DATA_W-1:0]    m_tdata
);
    import zvd_pkg::*;

    // configuration
    logic [NN_W-1:0]   spe_reg;
    logic [WIN_W-1:0]  bwin_reg;
    logic [SMW_W-1:0]  smw_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              auto_reg;
    logic [RATE_W-1:0] rate_reg;

    // algorithm state
    logic signed [SUM_W-1:0]  esum_reg [3];
    logic signed [BSUM_W-1:0] bsum_reg [3];
    logic signed [BIAS_W-1:0] bias_reg [3];
    logic [IDX_W-1:0]         idx_reg;
    logic [MAG_W-1:0]         mean_reg;
    logic [MAG_W-1:0]         dev_reg;
    logic                     seen_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     done_reg;
    logic                     stat_reg;
    logic                     aligned_reg;

    // working registers
    logic [1:0]               axis_reg;
    logic [2*SUM_W-1:0]       sqp_reg;
    logic [RAD_W-1:0]         sq_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [BSUM_W-1:0]        mcand_reg;
    logic [RATE_W-1:0]        mplier_reg;
    logic [DIV_W-1:0]         acc_reg;
    logic [3:0]               mcnt_reg;
    logic                     m_tvalid_reg;
    logic [M_DATA_W-1:0]      m_tdata_reg;

    logic [NN_W-1:0]          nn;
    logic [WIN_W-1:0]         w;
    logic [SMW_W-1:0]         n;
    logic [19:0]              wn;
    logic [DEN_W-1:0]         den;
    logic signed [SUM_W-1:0]  esum_sel;
    logic signed [BSUM_W-1:0] bsum_sel;
    logic [SUM_W-1:0]         esum_abs;
    logic [BSUM_W-1:0]        bsum_abs;
    logic [SUM_W-1:0]         avg_num;
    logic [MAG_W-1:0]         ad;
    logic [PROD_W:0]          smooth_num;
    logic [DIV_W-1:0]         div_dividend;
    logic [DEN_W-1:0]         div_divisor;
    logic [STEP_W-1:0]        div_steps;
    logic                     div_busy;
    logic [DIV_W-1:0]         div_quo;
    logic                     sqrt_busy;
    logic [ROOT_W-1:0]        sqrt_root;
    logic                     neg;
    logic [DIV_W-1:0]         lim;
    logic [BIAS_W-1:0]        bias_mag;
    logic [BIAS_W-1:0]        bias_new;
    logic                     stat_new;
    logic [SAMPLE_W-1:0]      smp [3];

    // clamp the configuration to working ranges
    always_comb begin
        if (spe_reg == '0)
            nn = 5'd1;
        else if (spe_reg > NN_W'(MAX_SUB))
            nn = NN_W'(MAX_SUB);
        else
            nn = spe_reg;
        w  = (bwin_reg == '0) ? 16'd1 : bwin_reg;
        n  = (smw_reg == '0) ? 11'd1 : smw_reg;
        wn = 20'(w) * 20'(nn);
        den = {wn, 8'd0};
    end

    // operands of the selected axis
    always_comb begin
        esum_sel = esum_reg[axis_reg];
        bsum_sel = bsum_reg[axis_reg];
        esum_abs = esum_sel[SUM_W-1] ? SUM_W'(-esum_sel) : SUM_W'(esum_sel);
        bsum_abs = bsum_sel[BSUM_W-1] ? BSUM_W'(-bsum_sel) : BSUM_W'(bsum_sel);
        avg_num  = esum_abs + SUM_W'(nn[NN_W-1:1]);
        ad       = (mean_reg >= mag_reg) ? (mean_reg - mag_reg) : (mag_reg - mean_reg);
    end

    // build the divider operands, left aligned to the step count
    always_comb begin
        smooth_num = {1'b0, prod_reg} + (PROD_W+1)'(n[SMW_W-1:1]);
        if (cmd.div_op == DIV_DEV)
            smooth_num = smooth_num + (PROD_W+1)'(ad);
        else
            smooth_num = smooth_num + (PROD_W+1)'(mag_reg);
        case (cmd.div_op)
            DIV_AVG: begin
                div_dividend = {avg_num, (DIV_W-SUM_W)'(0)};
                div_divisor  = DEN_W'(nn);
                div_steps    = STEP_W'(SUM_W);
            end
            DIV_BIAS: begin
                div_dividend = acc_reg + DIV_W'(den[DEN_W-1:1]);
                div_divisor  = den;
                div_steps    = STEP_W'(DIV_W);
            end
            DIV_MEAN, DIV_DEV: begin
                div_dividend = {smooth_num, (DIV_W-PROD_W-1)'(0)};
                div_divisor  = DEN_W'(n);
                div_steps    = STEP_W'(PROD_W+1);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = DEN_W'(1);
                div_steps    = '0;
            end
        endcase
    end

    zvd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    zvd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (sq_reg),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // round-to-nearest bias with signed saturation
    always_comb begin
        neg      = bsum_sel[BSUM_W-1];
        lim      = neg ? DIV_W'(33'h0_8000_0000) : DIV_W'(33'h0_7FFF_FFFF);
        bias_mag = (div_quo > lim) ? lim[BIAS_W-1:0] : div_quo[BIAS_W-1:0];
        bias_new = neg ? BIAS_W'(-bias_mag) : bias_mag;
        stat_new = (dev_reg != '0) && (dev_reg < thr_reg);
    end

    assign smp[0] = s_tdata[SAMPLE_W-1:0];
    assign smp[1] = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign smp[2] = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spe_reg  <= 5'd1;
            bwin_reg <= 16'd4000;
            smw_reg  <= 11'd16;
            thr_reg  <= 24'd4096;
            auto_reg <= 1'b1;
            rate_reg <= 13'd200;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SPE:    spe_reg  <= cfg_data[NN_W-1:0];
                REG_BWIN:   bwin_reg <= cfg_data[WIN_W-1:0];
                REG_SMOOTH: smw_reg  <= cfg_data[SMW_W-1:0];
                REG_THR:    thr_reg  <= cfg_data[THR_W-1:0];
                REG_AUTO:   auto_reg <= cfg_data[0];
                REG_RATE:   rate_reg <= cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // epoch and bias sums, bias values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                esum_reg[i] <= '0;
                bsum_reg[i] <= '0;
                bias_reg[i] <= '0;
            end
            idx_reg     <= '0;
            aligned_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            if (cmd.accept) begin
                for (int i = 0; i < 3; i++)
                    esum_reg[i] <= esum_reg[i] + SUM_W'($signed(smp[i]));
                idx_reg     <= idx_reg + 1'b1;
                aligned_reg <= s_tuser;
            end
            if (cmd.stat_update) begin
                for (int i = 0; i < 3; i++)
                    esum_reg[i] <= '0;
                idx_reg <= '0;
            end
            if (cmd.bias_gather) begin
                for (int i = 0; i < 3; i++)
                    bsum_reg[i] <= bsum_reg[i] + BSUM_W'(esum_reg[i]);
            end
            if (cmd.bias_clear) begin
                for (int i = 0; i < 3; i++)
                    bsum_reg[i] <= '0;
            end
            if (cmd.bias_store)
                bias_reg[axis_reg] <= bias_new;
            if (cmd.bias_done_set)
                done_reg <= 1'b1;
        end
    end

    // magnitude, running means, still counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg <= '0;
            dev_reg  <= '0;
            seen_reg <= 1'b0;
            cnt_reg  <= '0;
            stat_reg <= 1'b0;
            axis_reg <= '0;
        end else begin
            if (cmd.axis_clr)
                axis_reg <= '0;
            else if (cmd.axis_inc)
                axis_reg <= axis_reg + 1'b1;
            if (cmd.mean_seed) begin
                mean_reg <= mag_reg;
                dev_reg  <= '0;
                seen_reg <= 1'b1;
            end
            if (cmd.mean_load)
                mean_reg <= div_quo[MAG_W-1:0];
            if (cmd.dev_seed)
                dev_reg <= ad;
            if (cmd.dev_load)
                dev_reg <= div_quo[MAG_W-1:0];
            if (cmd.stat_update) begin
                stat_reg <= stat_new;
                if (!stat_new)
                    cnt_reg <= '0;
                else if (cnt_reg != '1)
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // working registers: squares, products, bias multiplier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcnt_reg <= '0;
        end else if (cmd.mul_start) begin
            mcnt_reg <= 4'(RATE_W);
        end else if (mcnt_reg != '0) begin
            mcnt_reg <= mcnt_reg - 1'b1;
        end
        if (cmd.accept)
            sq_reg <= '0;
        else if (cmd.sq_add)
            sq_reg <= sq_reg + RAD_W'(sqp_reg);
        if (cmd.sq_mul)
            sqp_reg <= div_quo[SUM_W-1:0] * div_quo[SUM_W-1:0];
        if (cmd.mag_load)
            mag_reg <= (sqrt_root > ROOT_W'({MAG_W{1'b1}})) ? '1 : sqrt_root[MAG_W-1:0];
        if (cmd.mean_mul)
            prod_reg <= PROD_W'(n - 1'b1) * PROD_W'(mean_reg);
        else if (cmd.dev_mul)
            prod_reg <= PROD_W'(n - 1'b1) * PROD_W'(dev_reg);
        // shift-add multiply, multiplier bits MSB first
        if (cmd.mul_start) begin
            mcand_reg  <= bsum_abs;
            mplier_reg <= rate_reg;
            acc_reg    <= '0;
        end else if (mcnt_reg != '0) begin
            acc_reg    <= {acc_reg[DIV_W-2:0], 1'b0}
                          + (mplier_reg[RATE_W-1] ? DIV_W'(mcand_reg) : '0);
            mplier_reg <= {mplier_reg[RATE_W-2:0], 1'b0};
        end
    end

    // output register, holds until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load)
            m_tdata_reg <= {6'd0, done_reg, bias_reg[2], bias_reg[1], bias_reg[0],
                            dev_reg, mean_reg, cnt_reg, stat_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // status to the controller
    always_comb begin
        sts.ep_end    = s_tlast || ((idx_reg + 1'b1) >= IDX_W'(nn));
        sts.div_busy  = div_busy;
        sts.sqrt_busy = sqrt_busy;
        sts.mul_busy  = (mcnt_reg != '0);
        sts.axis_last = (axis_reg == 2'd2);
        sts.aligned   = aligned_reg;
        sts.gather    = !aligned_reg && (cnt_reg != '0) && auto_reg && !done_reg;
        sts.bias_now  = (cnt_reg >= w);
        sts.seen      = seen_reg;
        sts.dev_zero  = (dev_reg == '0);
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule

// ===== design/zvd_ctrl.sv =====
// Controller: sequences the per-epoch computation over the shared divider,
// square root and bias multiplier. Depends on zvd_pkg.
module zvd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  zvd_pkg::zvd_sts_t  sts,
    output zvd_pkg::zvd_cmd_t  cmd
);
    import zvd_pkg::*;

    typedef enum logic [17:0] {
        ST_IDLE       = 18'h00001,
        ST_AVG_START  = 18'h00002,
        ST_AVG_WAIT   = 18'h00004,
        ST_SQ_ADD     = 18'h00008,
        ST_SQRT_START = 18'h00010,
        ST_SQRT_WAIT  = 18'h00020,
        ST_BIAS_SEL   = 18'h00040,
        ST_BMUL_START = 18'h00080,
        ST_BMUL_WAIT  = 18'h00100,
        ST_BDIV_WAIT  = 18'h00200,
        ST_MEAN_SEL   = 18'h00400,
        ST_MEAN_DIV   = 18'h00800,
        ST_MEAN_WAIT  = 18'h01000,
        ST_DEV_SEL    = 18'h02000,
        ST_DEV_DIV    = 18'h04000,
        ST_DEV_WAIT   = 18'h08000,
        ST_STAT       = 18'h10000,
        ST_OUT        = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = DIV_AVG;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && sts.ep_end) begin
                    cmd.axis_clr = 1'b1;
                    state_next   = ST_AVG_START;
                end
            end
            ST_AVG_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.sq_mul = 1'b1;
                    state_next = ST_SQ_ADD;
                end
            end
            ST_SQ_ADD: begin
                cmd.sq_add = 1'b1;
                if (sts.axis_last) begin
                    cmd.axis_clr = 1'b1;
                    state_next   = ST_SQRT_START;
                end else begin
                    cmd.axis_inc = 1'b1;
                    state_next   = ST_AVG_START;
                end
            end
            ST_SQRT_START: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (!sts.sqrt_busy) begin
                    cmd.mag_load = 1'b1;
                    state_next   = ST_BIAS_SEL;
                end
            end
            // gather or clear bias sums; hold them once aligned
            ST_BIAS_SEL: begin
                state_next = ST_MEAN_SEL;
                if (!sts.aligned) begin
                    if (sts.gather) begin
                        cmd.bias_gather = 1'b1;
                        if (sts.bias_now)
                            state_next = ST_BMUL_START;
                    end else begin
                        cmd.bias_clear = 1'b1;
                    end
                end
            end
            ST_BMUL_START: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_BMUL_WAIT;
            end
            ST_BMUL_WAIT: begin
                cmd.div_op = DIV_BIAS;
                if (!sts.mul_busy) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_BDIV_WAIT;
                end
            end
            ST_BDIV_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.bias_store = 1'b1;
                    if (sts.axis_last) begin
                        cmd.bias_done_set = 1'b1;
                        state_next        = ST_MEAN_SEL;
                    end else begin
                        cmd.axis_inc = 1'b1;
                        state_next   = ST_BMUL_START;
                    end
                end
            end
            ST_MEAN_SEL: begin
                if (sts.seen) begin
                    cmd.mean_mul = 1'b1;
                    state_next   = ST_MEAN_DIV;
                end else begin
                    cmd.mean_seed = 1'b1;
                    state_next    = ST_STAT;
                end
            end
            ST_MEAN_DIV: begin
                cmd.div_op    = DIV_MEAN;
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.mean_load = 1'b1;
                    state_next    = ST_DEV_SEL;
                end
            end
            ST_DEV_SEL: begin
                if (sts.dev_zero) begin
                    cmd.dev_seed = 1'b1;
                    state_next   = ST_STAT;
                end else begin
                    cmd.dev_mul = 1'b1;
                    state_next  = ST_DEV_DIV;
                end
            end
            ST_DEV_DIV: begin
                cmd.div_op    = DIV_DEV;
                cmd.div_start = 1'b1;
                state_next    = ST_DEV_WAIT;
            end
            ST_DEV_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.dev_load = 1'b1;
                    state_next   = ST_STAT;
                end
            end
            ST_STAT: begin
                cmd.stat_update = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/zero_velocity_detector_top.sv =====
// Zero-velocity detector from gyro increments. An item that does not end an
// epoch is accepted while the detector is idle. An epoch-ending item stops intake
// while the epoch is computed on the shared divider and the square root; the epoch
// that computes the gyro bias adds a multiply and a division for each of the three
// axes. A stalled result holds off intake. Synchronous active-low reset.
module zero_velocity_detector_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // gyro_x, gyro_y, gyro_z
    input  logic [zvd_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tlast,
    // aligned
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // stationary, still_epochs, magnitude_mean, magnitude_deviation,
    // bias_x, bias_y, bias_z, bias_valid, zero fill
    output logic [zvd_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [zvd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [zvd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import zvd_pkg::*;

    zvd_cmd_t cmd;
    zvd_sts_t sts;

    assign cfg_ready = 1'b1;

    zvd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    zvd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== design/zvd_checker.sv =====
// Port-level checks for the zero-velocity detector, bound to the top level.
// Depends on zvd_pkg.
module zvd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [zvd_pkg::M_DATA_W-1:0]    m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an epoch end stops intake while the epoch is computed
    a_busy_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("item taken during epoch computation");

    // still count is nonzero exactly when the epoch is stationary
    a_still_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[16:1] != 16'd0)))
        else $error("still count disagrees with stationary flag");

    // bias stays zero until it is computed
    a_bias_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[161] |-> (m_tdata[160:65] == 96'd0))
        else $error("bias nonzero before bias_valid");

    // reset drops the result valid
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind zero_velocity_detector_top zvd_checker u_zvd_checker (.*);
